FILE: rtl/src_pkg.sv
package src_pkg;

    parameter int COORD_BITS_DEF = 21;
    parameter int NUM_LANES = 3;

    // Which feature of the rectangle the sphere center projects onto.
    typedef enum logic [1:0] {
        MODE_FACE,
        MODE_EDGE_Y,
        MODE_EDGE_X,
        MODE_CORNER
    } mode_t;

endpackage

FILE: rtl/src_isqrt.sv
module src_isqrt #(
    parameter int W = 62,
    parameter int LANES = 2,
    parameter int TW = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [LANES-1:0][W-1:0]       rad,
    input  logic [TW-1:0]                 tag_in,
    output logic                          out_valid,
    output logic [LANES-1:0][W/2-1:0]     root,
    output logic [TW-1:0]                 tag_out
);

    localparam int K = W / 2;

    logic [K-1:0]             vld_reg;
    logic [LANES-1:0][W-1:0]  x_reg [K];
    logic [LANES-1:0][W-1:0]  res_reg [K];
    logic [TW-1:0]            tag_reg [K];

    logic [LANES-1:0][W-1:0]  x_in [K];
    logic [LANES-1:0][W-1:0]  res_in [K];
    logic [LANES-1:0][W-1:0]  trial [K];
    logic [LANES-1:0][W-1:0]  x_next [K];
    logic [LANES-1:0][W-1:0]  res_next [K];
    logic                     vld_in [K];
    logic [TW-1:0]            tag_in_s [K];

    // One result bit per stage, digit-by-digit square root.
    for (genvar k = 0; k < K; k++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);

        if (k == 0) begin : g_first
            assign x_in[k]     = rad;
            assign res_in[k]   = '0;
            assign vld_in[k]   = in_valid;
            assign tag_in_s[k] = tag_in;
        end else begin : g_next
            assign x_in[k]     = x_reg[k-1];
            assign res_in[k]   = res_reg[k-1];
            assign vld_in[k]   = vld_reg[k-1];
            assign tag_in_s[k] = tag_reg[k-1];
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[k][l] = res_in[k][l] + BIT;
                if (x_in[k][l] >= trial[k][l])
                begin
                    x_next[k][l]   = x_in[k][l] - trial[k][l];
                    res_next[k][l] = (res_in[k][l] >> 1) + BIT;
                end
                else
                begin
                    x_next[k][l]   = x_in[k][l];
                    res_next[k][l] = res_in[k][l] >> 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[k]   <= x_next[k];
            res_reg[k] <= res_next[k];
            tag_reg[k] <= tag_in_s[k];
        end
    end

    assign out_valid = vld_reg[K-1];
    assign tag_out   = tag_reg[K-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = res_reg[K-1][l][K-1:0];
        end
    end

endmodule

FILE: rtl/src_div.sv
module src_div #(
    parameter int NW = 51,
    parameter int DVW = 31,
    parameter int QB = 20,
    parameter int TW = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic [src_pkg::NUM_LANES-1:0][NW-1:0]   num,
    input  logic [DVW-1:0]                          den,
    input  logic [TW-1:0]                           tag_in,
    output logic                                    out_valid,
    output logic [src_pkg::NUM_LANES-1:0][QB-1:0]   quo,
    output logic [TW-1:0]                           tag_out
);

    localparam int NL = src_pkg::NUM_LANES;

    logic [QB-1:0]              vld_reg;
    logic [NL-1:0][NW-1:0]      rem_reg [QB];
    logic [NL-1:0][QB-1:0]      q_reg [QB];
    logic [DVW-1:0]             den_reg [QB];
    logic [TW-1:0]              tag_reg [QB];

    logic [NL-1:0][NW-1:0]      rem_in [QB];
    logic [NL-1:0][QB-1:0]      q_in [QB];
    logic [DVW-1:0]             den_in [QB];
    logic [TW-1:0]              tag_in_s [QB];
    logic                       vld_in [QB];
    logic [NW-1:0]              trial [QB];
    logic [NL-1:0][NW-1:0]      rem_next [QB];
    logic [NL-1:0][QB-1:0]      q_next [QB];

    // Restoring division, one quotient bit per stage, all lanes share the divisor.
    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int SH = QB - 1 - j;

        if (j == 0) begin : g_first
            assign rem_in[j]   = num;
            assign q_in[j]     = '0;
            assign den_in[j]   = den;
            assign tag_in_s[j] = tag_in;
            assign vld_in[j]   = in_valid;
        end else begin : g_next
            assign rem_in[j]   = rem_reg[j-1];
            assign q_in[j]     = q_reg[j-1];
            assign den_in[j]   = den_reg[j-1];
            assign tag_in_s[j] = tag_reg[j-1];
            assign vld_in[j]   = vld_reg[j-1];
        end

        assign trial[j] = NW'(den_in[j]) << SH;

        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (rem_in[j][l] >= trial[j])
                begin
                    rem_next[j][l] = rem_in[j][l] - trial[j];
                    q_next[j][l]   = q_in[j][l] | (QB'(1) << SH);
                end
                else
                begin
                    rem_next[j][l] = rem_in[j][l];
                    q_next[j][l]   = q_in[j][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next[j];
            q_reg[j]   <= q_next[j];
            den_reg[j] <= den_in[j];
            tag_reg[j] <= tag_in_s[j];
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign quo       = q_reg[QB-1];
    assign tag_out   = tag_reg[QB-1];

endmodule

FILE: rtl/sphere_rectangle_collision_top.sv
// Sphere against oriented rectangle, fully pipelined.
// Throughput: one item per cycle; busy is never raised.
// The done strobe follows the front stages, the square-root stages and the divider stages,
// then the final direction and saturation stages.
// Reset clears all valid bits; items in flight are dropped. The receiver cannot stall.
module sphere_rectangle_collision_top #(
    parameter int COORD_BITS = src_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [3*COORD_BITS-1:0]   sphere_center,
    input  logic [COORD_BITS-2:0]     sphere_radius,
    input  logic [3*COORD_BITS-1:0]   plane_center,
    input  logic [3*COORD_BITS-1:0]   plane_axis_x,
    input  logic [3*COORD_BITS-1:0]   plane_axis_y,
    input  logic [3*COORD_BITS-1:0]   plane_normal,
    input  logic [COORD_BITS-2:0]     half_extent_x,
    input  logic [COORD_BITS-2:0]     half_extent_y,
    output logic                      done,
    output logic                      hit,
    output logic [COORD_BITS-2:0]     depth,
    output logic [3*COORD_BITS-1:0]   push_direction,
    output logic [3*COORD_BITS-1:0]   contact_point
);

    localparam int NL   = src_pkg::NUM_LANES;
    localparam int C    = COORD_BITS;
    localparam int AF   = C - 2;
    localparam int MW   = C - 1;
    localparam int PW   = 2 * C + 1;
    localparam int SUMW = 2 * C + 3;
    localparam int DW   = C + 5;
    localparam int AW   = DW - 1;
    localparam int MPW  = C + DW;
    localparam int RSW  = C + 7;
    localparam int CPW  = C + 9;
    localparam int VW   = C + 10;
    localparam int VMW  = VW - 1;
    localparam int SQW  = 2 * AW;
    localparam int SW   = SQW + 2;
    localparam int RRW  = 2 * MW;
    localparam int VSQW = 2 * VMW;
    localparam int RW   = VSQW + 2;
    localparam int RTW  = RW / 2;
    localparam int QB   = AF + 1;
    localparam int NW   = RTW + QB;
    localparam int FPW  = C + AW + 1;
    localparam int LAT  = 2 * C + 19;

    localparam logic signed [FPW-1:0] SAT_HI = FPW'((1 << (C - 1)) - 1);
    localparam logic signed [FPW-1:0] SAT_LO = -SAT_HI - FPW'(1);

    typedef struct packed {
        logic [NL-1:0][C-1:0] x;
        logic [NL-1:0][C-1:0] p;
        logic [NL-1:0][C-1:0] ax;
        logic [NL-1:0][C-1:0] ay;
        logic [NL-1:0][C-1:0] n;
        logic [MW-1:0]        r;
        logic [MW-1:0]        hx;
        logic [MW-1:0]        hy;
    } geo_t;

    typedef struct packed {
        logic                   hit;
        logic                   face;
        logic [NL-1:0][VW-1:0]  v;
        logic [NL-1:0][CPW-1:0] cp;
        logic [NL-1:0][C-1:0]   x;
        logic [NL-1:0][C-1:0]   n;
        logic [MW-1:0]          r;
        logic [AW-1:0]          adm;
    } sq_tag_t;

    typedef struct packed {
        sq_tag_t        base;
        logic [RTW-1:0] len;
        logic [RTW-1:0] rts;
    } dv_tag_t;

    assign busy = 1'b0;

    // ---------------- stage 1: capture, center offset ----------------
    logic                    s1_vld_reg;
    geo_t                    s1_geo_reg;
    logic signed [C:0]       s1_d_reg [NL];

    always_ff @(posedge clk)
    begin
        s1_geo_reg.x  <= sphere_center;
        s1_geo_reg.p  <= plane_center;
        s1_geo_reg.ax <= plane_axis_x;
        s1_geo_reg.ay <= plane_axis_y;
        s1_geo_reg.n  <= plane_normal;
        s1_geo_reg.r  <= sphere_radius;
        s1_geo_reg.hx <= half_extent_x;
        s1_geo_reg.hy <= half_extent_y;
        for (int i = 0; i < NL; i++)
        begin
            s1_d_reg[i] <= (C+1)'($signed(sphere_center[i*C +: C]))
                         - (C+1)'($signed(plane_center[i*C +: C]));
        end
    end

    // ---------------- stage 2: lane products ----------------
    logic                    s2_vld_reg;
    geo_t                    s2_geo_reg;
    logic signed [PW-1:0]    s2_pr_reg [3][NL];

    always_ff @(posedge clk)
    begin
        s2_geo_reg <= s1_geo_reg;
        for (int i = 0; i < NL; i++)
        begin
            s2_pr_reg[0][i] <= PW'(s1_d_reg[i]) * PW'($signed(s1_geo_reg.n[i]));
            s2_pr_reg[1][i] <= PW'(s1_d_reg[i]) * PW'($signed(s1_geo_reg.ax[i]));
            s2_pr_reg[2][i] <= PW'(s1_d_reg[i]) * PW'($signed(s1_geo_reg.ay[i]));
        end
    end

    // ---------------- stage 3: dot sums with rounding ----------------
    logic                    s3_vld_reg;
    geo_t                    s3_geo_reg;
    logic signed [DW-1:0]    s3_dot_reg [3];
    logic signed [SUMW-1:0]  s3_sum [3];
    logic [SUMW-1:0]         s3_mag [3];
    logic [SUMW-1:0]         s3_rm [3];
    logic signed [DW-1:0]    s3_dot_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_sum[k] = SUMW'(s2_pr_reg[k][0]) + SUMW'(s2_pr_reg[k][1])
                      + SUMW'(s2_pr_reg[k][2]);
            s3_mag[k] = s3_sum[k][SUMW-1] ? -s3_sum[k] : s3_sum[k];
            s3_rm[k]  = (s3_mag[k] + (SUMW'(1) << (AF - 1))) >> AF;
            s3_dot_next[k] = s3_sum[k][SUMW-1] ? -DW'(s3_rm[k]) : DW'(s3_rm[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        s3_geo_reg <= s2_geo_reg;
        for (int k = 0; k < 3; k++)
        begin
            s3_dot_reg[k] <= s3_dot_next[k];
        end
    end

    // ---------------- stage 4: case selection ----------------
    logic [AW-1:0]           s4c_adm, s4c_alm, s4c_aym, s4c_exm, s4c_eym;
    logic signed [DW-1:0]    s4c_sx, s4c_sy, s4c_a, s4c_b;
    logic [AW-1:0]           s4c_e1, s4c_e2;
    logic                    s4c_face, s4c_contact;
    src_pkg::mode_t          s4c_mode;
    logic signed [C:0]       s4c_fv [NL];

    logic                    s4_vld_reg;
    geo_t                    s4_geo_reg;
    logic                    s4_face_reg, s4_contact_reg;
    logic signed [DW-1:0]    s4_a_reg, s4_b_reg;
    logic [AW-1:0]           s4_adm_reg, s4_e1_reg, s4_e2_reg;
    logic signed [C:0]       s4_fv_reg [NL];

    always_comb
    begin
        s4c_adm = s3_dot_reg[0][DW-1] ? AW'(-s3_dot_reg[0]) : AW'(s3_dot_reg[0]);
        s4c_alm = s3_dot_reg[1][DW-1] ? AW'(-s3_dot_reg[1]) : AW'(s3_dot_reg[1]);
        s4c_aym = s3_dot_reg[2][DW-1] ? AW'(-s3_dot_reg[2]) : AW'(s3_dot_reg[2]);
        s4c_contact = s4c_adm < AW'(s3_geo_reg.r);
        s4c_exm = s4c_alm - AW'(s3_geo_reg.hx);
        s4c_eym = s4c_aym - AW'(s3_geo_reg.hy);
        s4c_sx  = s3_dot_reg[1][DW-1] ? -DW'(s3_geo_reg.hx) : DW'(s3_geo_reg.hx);
        s4c_sy  = s3_dot_reg[2][DW-1] ? -DW'(s3_geo_reg.hy) : DW'(s3_geo_reg.hy);
        s4c_face = (s4c_alm < AW'(s3_geo_reg.hx)) && (s4c_aym < AW'(s3_geo_reg.hy));
        if (s4c_face)
        begin
            s4c_mode = src_pkg::MODE_FACE;
        end
        else if (s4c_alm < AW'(s3_geo_reg.hx))
        begin
            s4c_mode = src_pkg::MODE_EDGE_Y;
        end
        else if (s4c_aym < AW'(s3_geo_reg.hy))
        begin
            s4c_mode = src_pkg::MODE_EDGE_X;
        end
        else
        begin
            s4c_mode = src_pkg::MODE_CORNER;
        end
        case (s4c_mode)
            src_pkg::MODE_EDGE_Y:
            begin
                s4c_a  = s3_dot_reg[1];
                s4c_b  = s4c_sy;
                s4c_e1 = s4c_eym;
                s4c_e2 = '0;
            end
            src_pkg::MODE_EDGE_X:
            begin
                s4c_a  = s4c_sx;
                s4c_b  = s3_dot_reg[2];
                s4c_e1 = '0;
                s4c_e2 = s4c_exm;
            end
            src_pkg::MODE_CORNER:
            begin
                s4c_a  = s4c_sx;
                s4c_b  = s4c_sy;
                s4c_e1 = s4c_eym;
                s4c_e2 = s4c_exm;
            end
            default:
            begin
                s4c_a  = '0;
                s4c_b  = '0;
                s4c_e1 = '0;
                s4c_e2 = '0;
            end
        endcase
        // The face direction is the normal, flipped below the plane, zero on it.
        for (int i = 0; i < NL; i++)
        begin
            if (s3_dot_reg[0][DW-1])
            begin
                s4c_fv[i] = -(C+1)'($signed(s3_geo_reg.n[i]));
            end
            else if (s3_dot_reg[0] != '0)
            begin
                s4c_fv[i] = (C+1)'($signed(s3_geo_reg.n[i]));
            end
            else
            begin
                s4c_fv[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s4_geo_reg     <= s3_geo_reg;
        s4_face_reg    <= s4c_face;
        s4_contact_reg <= s4c_contact;
        s4_a_reg       <= s4c_a;
        s4_b_reg       <= s4c_b;
        s4_adm_reg     <= s4c_adm;
        s4_e1_reg      <= s4c_e1;
        s4_e2_reg      <= s4c_e2;
        for (int i = 0; i < NL; i++)
        begin
            s4_fv_reg[i] <= s4c_fv[i];
        end
    end

    // ---------------- stage 5: edge products and squares ----------------
    logic                    s5_vld_reg;
    geo_t                    s5_geo_reg;
    logic                    s5_face_reg, s5_contact_reg;
    logic [AW-1:0]           s5_adm_reg;
    logic signed [C:0]       s5_fv_reg [NL];
    logic signed [MPW-1:0]   s5_pa_reg [NL];
    logic signed [MPW-1:0]   s5_pb_reg [NL];
    logic [SQW-1:0]          s5_sq_reg [3];
    logic [RRW-1:0]          s5_rr_reg;

    always_ff @(posedge clk)
    begin
        s5_geo_reg     <= s4_geo_reg;
        s5_face_reg    <= s4_face_reg;
        s5_contact_reg <= s4_contact_reg;
        s5_adm_reg     <= s4_adm_reg;
        for (int i = 0; i < NL; i++)
        begin
            s5_fv_reg[i] <= s4_fv_reg[i];
            s5_pa_reg[i] <= MPW'($signed(s4_geo_reg.ax[i])) * MPW'(s4_a_reg);
            s5_pb_reg[i] <= MPW'($signed(s4_geo_reg.ay[i])) * MPW'(s4_b_reg);
        end
        s5_sq_reg[0] <= SQW'(s4_adm_reg) * SQW'(s4_adm_reg);
        s5_sq_reg[1] <= SQW'(s4_e1_reg) * SQW'(s4_e1_reg);
        s5_sq_reg[2] <= SQW'(s4_e2_reg) * SQW'(s4_e2_reg);
        s5_rr_reg    <= RRW'(s4_geo_reg.r) * RRW'(s4_geo_reg.r);
    end

    // ---------------- stage 6: contact point, hit test ----------------
    logic [SW-1:0]           s6c_s;
    logic [MPW-1:0]          s6c_ma [NL];
    logic [MPW-1:0]          s6c_mb [NL];
    logic [MPW-1:0]          s6c_ra [NL];
    logic [MPW-1:0]          s6c_rb [NL];
    logic signed [RSW-1:0]   s6c_sa [NL];
    logic signed [RSW-1:0]   s6c_sb [NL];
    logic signed [CPW-1:0]   s6c_cp [NL];
    sq_tag_t                 s6c_tag;

    logic                    s6_vld_reg;
    sq_tag_t                 s6_tag_reg;
    logic [SW-1:0]           s6_s_reg;

    always_comb
    begin
        s6c_s = SW'(s5_sq_reg[0]) + SW'(s5_sq_reg[1]) + SW'(s5_sq_reg[2]);
        s6c_tag.face = s5_face_reg;
        s6c_tag.hit  = s5_contact_reg && (s5_face_reg || (s6c_s < SW'(s5_rr_reg)));
        s6c_tag.x    = s5_geo_reg.x;
        s6c_tag.n    = s5_geo_reg.n;
        s6c_tag.r    = s5_geo_reg.r;
        s6c_tag.adm  = s5_adm_reg;
        for (int i = 0; i < NL; i++)
        begin
            s6c_ma[i] = s5_pa_reg[i][MPW-1] ? -s5_pa_reg[i] : s5_pa_reg[i];
            s6c_mb[i] = s5_pb_reg[i][MPW-1] ? -s5_pb_reg[i] : s5_pb_reg[i];
            s6c_ra[i] = (s6c_ma[i] + (MPW'(1) << (AF - 1))) >> AF;
            s6c_rb[i] = (s6c_mb[i] + (MPW'(1) << (AF - 1))) >> AF;
            s6c_sa[i] = s5_pa_reg[i][MPW-1] ? -RSW'(s6c_ra[i]) : RSW'(s6c_ra[i]);
            s6c_sb[i] = s5_pb_reg[i][MPW-1] ? -RSW'(s6c_rb[i]) : RSW'(s6c_rb[i]);
            s6c_cp[i] = CPW'($signed(s5_geo_reg.p[i])) + CPW'(s6c_sa[i])
                      + CPW'(s6c_sb[i]);
            s6c_tag.cp[i] = s6c_cp[i];
            if (s5_face_reg)
            begin
                s6c_tag.v[i] = VW'(s5_fv_reg[i]);
            end
            else
            begin
                s6c_tag.v[i] = VW'($signed(s5_geo_reg.x[i])) - VW'(s6c_cp[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s6_tag_reg <= s6c_tag;
        s6_s_reg   <= s6c_s;
    end

    // ---------------- stage 7: squares of the direction vector ----------------
    logic [VMW-1:0]          s7c_vm [NL];
    logic                    s7_vld_reg;
    sq_tag_t                 s7_tag_reg;
    logic [SW-1:0]           s7_s_reg;
    logic [VSQW-1:0]         s7_vsq_reg [NL];

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            s7c_vm[i] = s6_tag_reg.v[i][VW-1] ? VMW'(-s6_tag_reg.v[i])
                                              : VMW'(s6_tag_reg.v[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        s7_tag_reg <= s6_tag_reg;
        s7_s_reg   <= s6_s_reg;
        for (int i = 0; i < NL; i++)
        begin
            s7_vsq_reg[i] <= VSQW'(s7c_vm[i]) * VSQW'(s7c_vm[i]);
        end
    end

    // ---------------- stage 8: radicands ----------------
    logic                    s8_vld_reg;
    sq_tag_t                 s8_tag_reg;
    logic [1:0][RW-1:0]      s8_rad_reg;

    always_ff @(posedge clk)
    begin
        s8_tag_reg    <= s7_tag_reg;
        s8_rad_reg[0] <= RW'(s7_vsq_reg[0]) + RW'(s7_vsq_reg[1]) + RW'(s7_vsq_reg[2]);
        s8_rad_reg[1] <= RW'(s7_s_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    // ---------------- square roots: vector length and feature distance ----------------
    logic                        sq_vld;
    logic [1:0][RTW-1:0]         sq_root;
    logic [$bits(sq_tag_t)-1:0]  sq_tag_vec;
    sq_tag_t                     sq_tag;

    src_isqrt #(
        .W     (RW),
        .LANES (2),
        .TW    ($bits(sq_tag_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s8_vld_reg),
        .rad       (s8_rad_reg),
        .tag_in    (s8_tag_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .tag_out   (sq_tag_vec)
    );

    assign sq_tag = sq_tag_vec;

    // ---------------- normalizing divider ----------------
    logic [NL-1:0][NW-1:0]       dv_num;
    logic [VMW-1:0]              dv_vm [NL];
    dv_tag_t                     dv_tag_in;
    logic                        dv_vld;
    logic [NL-1:0][QB-1:0]       dv_quo;
    logic [$bits(dv_tag_t)-1:0]  dv_tag_vec;
    dv_tag_t                     dv_tag;

    always_comb
    begin
        dv_tag_in.base = sq_tag;
        dv_tag_in.len  = sq_root[0];
        dv_tag_in.rts  = sq_root[1];
        for (int i = 0; i < NL; i++)
        begin
            dv_vm[i]  = sq_tag.v[i][VW-1] ? VMW'(-sq_tag.v[i]) : VMW'(sq_tag.v[i]);
            dv_num[i] = (NW'(dv_vm[i]) << AF) + NW'(sq_root[0] >> 1);
        end
    end

    src_div #(
        .NW  (NW),
        .DVW (RTW),
        .QB  (QB),
        .TW  ($bits(dv_tag_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .num       (dv_num),
        .den       (sq_root[0]),
        .tag_in    (dv_tag_in),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .tag_out   (dv_tag_vec)
    );

    assign dv_tag = dv_tag_vec;

    // ---------------- final stage 1: direction, depth, face product ----------------
    logic signed [C-1:0]     f1c_dir [NL];
    logic [MW-1:0]           f1c_depth;

    logic                    f1_vld_reg;
    logic                    f1_hit_reg, f1_face_reg;
    logic [MW-1:0]           f1_depth_reg;
    logic signed [C-1:0]     f1_dir_reg [NL];
    logic signed [FPW-1:0]   f1_fprod_reg [NL];
    logic signed [CPW-1:0]   f1_cp_reg [NL];
    logic signed [C-1:0]     f1_x_reg [NL];

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            if (dv_tag.len == '0)
            begin
                f1c_dir[i] = $signed(dv_tag.base.n[i]);
            end
            else if (dv_tag.base.v[i][VW-1])
            begin
                f1c_dir[i] = -C'(dv_quo[i]);
            end
            else
            begin
                f1c_dir[i] = C'(dv_quo[i]);
            end
        end
        if (dv_tag.base.face)
        begin
            f1c_depth = dv_tag.base.r - MW'(dv_tag.base.adm);
        end
        else
        begin
            f1c_depth = dv_tag.base.r - MW'(dv_tag.rts);
        end
    end

    always_ff @(posedge clk)
    begin
        f1_hit_reg   <= dv_tag.base.hit;
        f1_face_reg  <= dv_tag.base.face;
        f1_depth_reg <= f1c_depth;
        for (int i = 0; i < NL; i++)
        begin
            f1_dir_reg[i]   <= f1c_dir[i];
            f1_fprod_reg[i] <= FPW'(f1c_dir[i]) * $signed(FPW'(dv_tag.base.adm));
            f1_cp_reg[i]    <= $signed(dv_tag.base.cp[i]);
            f1_x_reg[i]     <= $signed(dv_tag.base.x[i]);
        end
    end

    // ---------------- final stage 2: face contact point, saturation ----------------
    logic [FPW-1:0]          f2c_mag [NL];
    logic [FPW-1:0]          f2c_rm [NL];
    logic signed [FPW-1:0]   f2c_sc [NL];
    logic signed [FPW-1:0]   f2c_cp [NL];
    logic signed [FPW-1:0]   f2c_sat [NL];

    logic                    done_reg, hit_reg;
    logic [MW-1:0]           depth_reg;
    logic [3*C-1:0]          push_reg, contact_reg;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            f2c_mag[i] = f1_fprod_reg[i][FPW-1] ? -f1_fprod_reg[i] : f1_fprod_reg[i];
            f2c_rm[i]  = (f2c_mag[i] + (FPW'(1) << (AF - 1))) >> AF;
            f2c_sc[i]  = f1_fprod_reg[i][FPW-1] ? -f2c_rm[i] : f2c_rm[i];
            if (f1_face_reg)
            begin
                f2c_cp[i] = FPW'(f1_x_reg[i]) - f2c_sc[i];
            end
            else
            begin
                f2c_cp[i] = FPW'(f1_cp_reg[i]);
            end
            if (f2c_cp[i] > SAT_HI)
            begin
                f2c_sat[i] = SAT_HI;
            end
            else if (f2c_cp[i] < SAT_LO)
            begin
                f2c_sat[i] = SAT_LO;
            end
            else
            begin
                f2c_sat[i] = f2c_cp[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= f1_hit_reg;
        depth_reg <= f1_hit_reg ? f1_depth_reg : '0;
        for (int i = 0; i < NL; i++)
        begin
            push_reg[i*C +: C]    <= f1_hit_reg ? f1_dir_reg[i] : '0;
            contact_reg[i*C +: C] <= f1_hit_reg ? C'(f2c_sat[i]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= dv_vld;
            done_reg   <= f1_vld_reg;
        end
    end

    assign done           = done_reg;
    assign hit            = done_reg && hit_reg;
    assign depth          = depth_reg;
    assign push_direction = push_reg;
    assign contact_point  = contact_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("item did not complete at the expected latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without a matching item");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> depth == '0 && push_direction == '0 && contact_point == '0)
        else $error("miss result carries nonzero fields");

    a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> depth != '0)
        else $error("hit result with zero depth");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CB = src_pkg::COORD_BITS_DEF;
    localparam int AF = CB - 2;
    localparam int LW = 3 * CB;
    localparam longint LANE_HI = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint LANE_LO = -(64'sd1 <<< (CB - 1));
    localparam real ONE_AXIS = 524288.0;
    localparam real ONE_COORD = 1024.0;

    typedef struct {
        logic [LW-1:0] sc;
        logic [CB-2:0] rad;
        logic [LW-1:0] pc;
        logic [LW-1:0] ax;
        logic [LW-1:0] ay;
        logic [LW-1:0] nrm;
        logic [CB-2:0] hx;
        logic [CB-2:0] hy;
    } query_t;

    typedef struct {
        logic          hit;
        logic [CB-2:0] depth;
        logic [LW-1:0] dir;
        logic [LW-1:0] cp;
    } contact_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [LW-1:0] sphere_center = '0;
    logic [CB-2:0] sphere_radius = '0;
    logic [LW-1:0] plane_center = '0;
    logic [LW-1:0] plane_axis_x = '0;
    logic [LW-1:0] plane_axis_y = '0;
    logic [LW-1:0] plane_normal = '0;
    logic [CB-2:0] half_extent_x = '0;
    logic [CB-2:0] half_extent_y = '0;
    logic done;
    logic hit;
    logic [CB-2:0] depth;
    logic [LW-1:0] push_direction;
    logic [LW-1:0] contact_point;

    contact_t pending_contacts[$];
    int errors = 0;
    int burst_left = 0;

    sphere_rectangle_collision_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sphere_center(sphere_center), .sphere_radius(sphere_radius),
        .plane_center(plane_center), .plane_axis_x(plane_axis_x),
        .plane_axis_y(plane_axis_y), .plane_normal(plane_normal),
        .half_extent_x(half_extent_x), .half_extent_y(half_extent_y),
        .done(done), .hit(hit), .depth(depth),
        .push_direction(push_direction), .contact_point(contact_point)
    );

    always #2 clk = ~clk;

    // ---------------- collision predictor ----------------

    function automatic longint lane_of(logic [LW-1:0] pk, int i);
        logic signed [CB-1:0] u;
        u = pk[i*CB +: CB];
        return longint'(u);
    endfunction

    function automatic longint clamp_lane(longint v);
        if (v > LANE_HI) return LANE_HI;
        if (v < LANE_LO) return LANE_LO;
        return v;
    endfunction

    function automatic logic [LW-1:0] pack_lanes(longint v0, longint v1, longint v2);
        logic [CB-1:0] a, b, c;
        a = CB'(clamp_lane(v0));
        b = CB'(clamp_lane(v1));
        c = CB'(clamp_lane(v2));
        return {c, b, a};
    endfunction

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Shift right with rounding half away from zero.
    function automatic longint round_down_bits(longint v, int s);
        longint unsigned m;
        m = (absval(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit to_unit(longint v[3], output longint o[3]);
        longint unsigned sq, len, q;
        sq = 0;
        for (int i = 0; i < 3; i++) sq += absval(v[i]) * absval(v[i]);
        len = int_sqrt(sq);
        if (len == 0) return 0;
        for (int i = 0; i < 3; i++)
        begin
            q = ((absval(v[i]) << AF) + len / 2) / len;
            o[i] = clamp_lane(v[i] < 0 ? -longint'(q) : longint'(q));
        end
        return 1;
    endfunction

    function automatic contact_t predict_contact(query_t q);
        contact_t res;
        longint sx[3], pp[3], ux[3], uy[3], nn[3], dd[3], cp[3], dir[3], vv[3];
        longint r, hx, hy, pdist, lx, ly, adist, alx, aly, ex, ey, sgx, sgy, dpt;
        longint dsum, xsum, ysum;
        longint unsigned s;
        bit inside_x, inside_y;
        res = '{hit: 0, depth: '0, dir: '0, cp: '0};
        r = longint'(q.rad);
        hx = longint'(q.hx);
        hy = longint'(q.hy);
        for (int i = 0; i < 3; i++)
        begin
            sx[i] = lane_of(q.sc, i);
            pp[i] = lane_of(q.pc, i);
            ux[i] = lane_of(q.ax, i);
            uy[i] = lane_of(q.ay, i);
            nn[i] = lane_of(q.nrm, i);
            dd[i] = sx[i] - pp[i];
        end
        dsum = 0; xsum = 0; ysum = 0;
        for (int i = 0; i < 3; i++)
        begin
            dsum += dd[i] * nn[i];
            xsum += dd[i] * ux[i];
            ysum += dd[i] * uy[i];
        end
        pdist = round_down_bits(dsum, AF);
        lx = round_down_bits(xsum, AF);
        ly = round_down_bits(ysum, AF);
        adist = pdist < 0 ? -pdist : pdist;
        alx = lx < 0 ? -lx : lx;
        aly = ly < 0 ? -ly : ly;
        if (!(adist < r)) return res;
        inside_x = alx < hx;
        inside_y = aly < hy;
        if (inside_x && inside_y)
        begin
            for (int i = 0; i < 3; i++)
                vv[i] = pdist < 0 ? -nn[i] : (pdist > 0 ? nn[i] : 0);
            if (!to_unit(vv, dir))
                dir = nn;
            dpt = r - adist;
            for (int i = 0; i < 3; i++)
                cp[i] = sx[i] - round_down_bits(dir[i] * adist, AF);
        end
        else
        begin
            s = absval(pdist) * absval(pdist);
            ex = alx - hx;
            ey = aly - hy;
            sgx = lx < 0 ? -hx : hx;
            sgy = ly < 0 ? -hy : hy;
            if (inside_x)
            begin
                s += absval(ey) * absval(ey);
                for (int i = 0; i < 3; i++)
                    cp[i] = pp[i] + round_down_bits(ux[i] * lx, AF)
                            + round_down_bits(uy[i] * sgy, AF);
            end
            else if (inside_y)
            begin
                s += absval(ex) * absval(ex);
                for (int i = 0; i < 3; i++)
                    cp[i] = pp[i] + round_down_bits(uy[i] * ly, AF)
                            + round_down_bits(ux[i] * sgx, AF);
            end
            else
            begin
                s += absval(ex) * absval(ex) + absval(ey) * absval(ey);
                for (int i = 0; i < 3; i++)
                    cp[i] = pp[i] + round_down_bits(ux[i] * sgx, AF)
                            + round_down_bits(uy[i] * sgy, AF);
            end
            if (!(s < longint'(r) * longint'(r))) return res;
            dpt = r - longint'(int_sqrt(s));
            for (int i = 0; i < 3; i++) vv[i] = sx[i] - cp[i];
            if (!to_unit(vv, dir))
                dir = nn;
        end
        res.hit = 1;
        res.depth = dpt[CB-2:0];
        res.dir = pack_lanes(dir[0], dir[1], dir[2]);
        res.cp = pack_lanes(cp[0], cp[1], cp[2]);
        return res;
    endfunction

    // ---------------- driving ----------------

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_query(query_t q);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start <= 1;
        sphere_center <= q.sc;
        sphere_radius <= q.rad;
        plane_center <= q.pc;
        plane_axis_x <= q.ax;
        plane_axis_y <= q.ay;
        plane_normal <= q.nrm;
        half_extent_x <= q.hx;
        half_extent_y <= q.hy;
        pending_contacts.push_back(predict_contact(q));
        do @(posedge clk); while (busy);
    endtask

    always @(posedge clk)
    begin
        contact_t e;
        if (rst_n && done)
        begin
            if (pending_contacts.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                e = pending_contacts.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit expected %0h actual %0h", e.hit, hit);
                    errors++;
                end
                if (depth !== e.depth)
                begin
                    $error("depth expected %0h actual %0h", e.depth, depth);
                    errors++;
                end
                if (push_direction !== e.dir)
                begin
                    $error("push_direction expected %0h actual %0h", e.dir, push_direction);
                    errors++;
                end
                if (contact_point !== e.cp)
                begin
                    $error("contact_point expected %0h actual %0h", e.cp, contact_point);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [LW-1:0] axis_vec(real a, real b, real c);
        return pack_lanes(longint'(a * ONE_AXIS), longint'(b * ONE_AXIS),
                          longint'(c * ONE_AXIS));
    endfunction

    function automatic logic [LW-1:0] coord_vec(longint a, longint b, longint c);
        return pack_lanes(a, b, c);
    endfunction

    function automatic real rnd_span(real span);
        return (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0 * span;
    endfunction

    // A plausible rectangle and a sphere placed around it in local coordinates.
    function automatic query_t random_scene();
        query_t q;
        real ang, c, s, fx[3], fy[3], fn[3], ox[3], oy[3], on[3], a, b, h, sn;
        longint pc[3], xc[3];
        int k;
        ang = real'($urandom_range(0, 3599)) * 3.14159265 / 1800.0;
        c = $cos(ang);
        s = $sin(ang);
        sn = $urandom_range(0, 1) ? 1.0 : -1.0;
        fx = '{c, s, 0.0};
        fy = '{-s, c, 0.0};
        fn = '{0.0, 0.0, sn};
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
        begin
            ox[(i + k) % 3] = fx[i];
            oy[(i + k) % 3] = fy[i];
            on[(i + k) % 3] = fn[i];
        end
        q.hx = (CB-1)'($urandom_range(0, 7) == 0 ? $urandom_range(0, 1048575)
                                                 : $urandom_range(16, 8192));
        q.hy = (CB-1)'($urandom_range(0, 7) == 0 ? $urandom_range(0, 1048575)
                                                 : $urandom_range(16, 8192));
        q.rad = (CB-1)'($urandom_range(0, 15) == 0 ? $urandom_range(0, 1048575)
                                                   : $urandom_range(32, 6000));
        a = rnd_span((real'(q.hx) + real'(q.rad)) * 1.3);
        b = rnd_span((real'(q.hy) + real'(q.rad)) * 1.3);
        h = rnd_span(real'(q.rad) * 1.2);
        for (int i = 0; i < 3; i++)
        begin
            pc[i] = longint'(rnd_span(200000.0));
            xc[i] = pc[i] + longint'(a * ox[i] + b * oy[i] + h * on[i]);
        end
        q.pc = coord_vec(pc[0], pc[1], pc[2]);
        q.sc = coord_vec(xc[0], xc[1], xc[2]);
        q.ax = axis_vec(ox[0], ox[1], ox[2]);
        q.ay = axis_vec(oy[0], oy[1], oy[2]);
        q.nrm = axis_vec(on[0], on[1], on[2]);
        return q;
    endfunction

    function automatic logic [LW-1:0] rnd_wide();
        return LW'({$urandom(), $urandom()});
    endfunction

    function automatic query_t random_noise();
        query_t q;
        q.sc = rnd_wide();
        q.rad = (CB-1)'($urandom());
        q.pc = rnd_wide();
        q.ax = rnd_wide();
        q.ay = rnd_wide();
        q.nrm = rnd_wide();
        q.hx = (CB-1)'($urandom());
        q.hy = (CB-1)'($urandom());
        return q;
    endfunction

    // Axis-aligned rectangle at the origin, normal along z.
    function automatic query_t flat_query(longint x, longint y, longint z,
                                          int r, int hx, int hy);
        query_t q;
        q.sc = coord_vec(x, y, z);
        q.rad = (CB-1)'(r);
        q.pc = '0;
        q.ax = axis_vec(1.0, 0.0, 0.0);
        q.ay = axis_vec(0.0, 1.0, 0.0);
        q.nrm = axis_vec(0.0, 0.0, 1.0);
        q.hx = (CB-1)'(hx);
        q.hy = (CB-1)'(hy);
        return q;
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed();
        query_t q;
        send_query(flat_query(100, -200, 500, 1024, 2048, 2048));
        send_query(flat_query(-300, 100, -500, 1024, 2048, 2048));
        send_query(flat_query(0, 0, 0, 1024, 2048, 2048));
        send_query(flat_query(0, 2500, 200, 1024, 2048, 2048));
        send_query(flat_query(0, -2500, -200, 1024, 2048, 2048));
        send_query(flat_query(2500, 0, 300, 1024, 2048, 2048));
        send_query(flat_query(-2500, 100, 0, 1024, 2048, 2048));
        send_query(flat_query(2300, 2300, 100, 1024, 2048, 2048));
        send_query(flat_query(-2300, -2300, -100, 1024, 2048, 2048));
        send_query(flat_query(2048, 0, 0, 1024, 2048, 2048));
        send_query(flat_query(2048, 2048, 0, 1024, 2048, 2048));
        send_query(flat_query(0, 0, 1024, 1024, 2048, 2048));
        send_query(flat_query(0, 0, 1023, 1024, 2048, 2048));
        send_query(flat_query(3072, 0, 0, 1024, 2048, 2048));
        send_query(flat_query(5000, 5000, 5000, 1024, 2048, 2048));
        send_query(flat_query(0, 0, 0, 0, 0, 0));
        send_query(flat_query(0, 0, 10, 1048575, 0, 0));
        send_query(flat_query(LANE_HI, LANE_LO, LANE_HI, 1048575, 1048575, 1048575));
        send_query(flat_query(LANE_LO, LANE_HI, LANE_LO, 1048575, 1048575, 1048575));
        q = flat_query(100, 100, 0, 1024, 2048, 2048);
        q.nrm = '0;
        send_query(q);
        q.sc = '0; q.rad = '0; q.pc = '0; q.ax = '0; q.ay = '0; q.nrm = '0;
        q.hx = '0; q.hy = '0;
        send_query(q);
        q.sc = '1; q.rad = '1; q.pc = '1; q.ax = '1; q.ay = '1; q.nrm = '1;
        q.hx = '1; q.hy = '1;
        send_query(q);
        q = flat_query(0, 0, 0, 1048575, 1048575, 1048575);
        q.pc = coord_vec(LANE_HI, LANE_HI, LANE_HI);
        q.sc = coord_vec(LANE_LO, LANE_LO, LANE_LO);
        send_query(q);
    endtask

    task automatic test_random_scenes(int count);
        repeat (count) send_query(random_scene());
    endtask

    task automatic test_random_noise(int count);
        repeat (count) send_query(random_noise());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random_scenes(1100);
        test_random_noise(180);
        start <= 0;
        while (pending_contacts.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
